// ===== sv/scmpw_pkg.sv =====
// Shared constants, types and helpers for the SCC condensation path-weight block.
package scmpw_pkg;

  localparam int NODE_MAX = 4096;
  localparam int EDGE_MAX = 65536;
  localparam int ID_W     = 13;
  localparam int WT_W     = 16;
  localparam int SUM_W    = 28;
  localparam int NIDX_W   = $clog2(NODE_MAX);
  localparam int CNT_W    = NIDX_W + 1;
  localparam int EIDX_W   = $clog2(EDGE_MAX);
  localparam int ELINK_W  = EIDX_W + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
  localparam logic [1:0] FUNC_EDGE    = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_LINK, OP_ROOT, OP_ROOT_CHK, OP_HEAD, OP_EDGE, OP_EDGE_RD,
    OP_NBR, OP_POP, OP_SUM_K, OP_SUM_W, OP_SUM_H, OP_SUM_F, OP_SUM_E, OP_SUM_C,
    OP_SUM_B, OP_RET, OP_RET_RD, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic res_valid;
    logic item_edge;
    logic item_compute;
    logic root_done;
    logic disc_zero;
    logic e_zero;
    logic scc_root;
    logic v_out;
    logic pop_last;
    logic k_end;
    logic f_zero;
    logic c_self;
    logic csp_zero;
    logic clr_last;
  } stat_t;

  typedef struct packed {
    logic [NIDX_W-1:0]  node;
    logic [ELINK_W-1:0] edge_ptr;
    logic [CNT_W-1:0]   low;
    logic [CNT_W-1:0]   disc;
  } frame_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/scmpw_ctrl.sv =====
// Sequencer state machine for load, Tarjan search, component sums and clearing.
module scmpw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  scmpw_pkg::stat_t  st,
  output scmpw_pkg::cmd_t   cmd
);
  import scmpw_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR   = 20'h00001,
    S_IDLE    = 20'h00002,
    S_LINK    = 20'h00004,
    S_ROOT    = 20'h00008,
    S_ROOT_CHK= 20'h00010,
    S_HEAD    = 20'h00020,
    S_EDGE    = 20'h00040,
    S_EDGE_RD = 20'h00080,
    S_NBR     = 20'h00100,
    S_POP     = 20'h00200,
    S_SUM_K   = 20'h00400,
    S_SUM_W   = 20'h00800,
    S_SUM_H   = 20'h01000,
    S_SUM_F   = 20'h02000,
    S_SUM_E   = 20'h04000,
    S_SUM_C   = 20'h08000,
    S_SUM_B   = 20'h10000,
    S_RET     = 20'h20000,
    S_RET_RD  = 20'h40000,
    S_DONE    = 20'h80000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || (st.item_compute && st.res_valid);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.accept = accept;
    cmd.op     = OP_IDLE;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (accept && st.item_edge) state_next = S_LINK;
        else if (accept && st.item_compute) state_next = S_ROOT;
      end
      S_LINK: begin
        cmd.op = OP_LINK;
        state_next = S_IDLE;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        state_next = st.root_done ? S_DONE : S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        cmd.op = OP_ROOT_CHK;
        state_next = st.disc_zero ? S_HEAD : S_ROOT;
      end
      S_HEAD: begin
        cmd.op = OP_HEAD;
        state_next = S_EDGE;
      end
      S_EDGE: begin
        cmd.op = OP_EDGE;
        if (!st.e_zero) state_next = S_EDGE_RD;
        else if (st.scc_root) state_next = S_POP;
        else state_next = S_RET;
      end
      S_EDGE_RD: begin
        cmd.op = OP_EDGE_RD;
        state_next = st.v_out ? S_EDGE : S_NBR;
      end
      S_NBR: begin
        cmd.op = OP_NBR;
        state_next = st.disc_zero ? S_HEAD : S_EDGE;
      end
      S_POP: begin
        cmd.op = OP_POP;
        if (st.pop_last) state_next = S_SUM_K;
      end
      S_SUM_K: begin
        cmd.op = OP_SUM_K;
        state_next = st.k_end ? S_RET : S_SUM_W;
      end
      S_SUM_W: begin
        cmd.op = OP_SUM_W;
        state_next = S_SUM_H;
      end
      S_SUM_H: begin
        cmd.op = OP_SUM_H;
        state_next = S_SUM_F;
      end
      S_SUM_F: begin
        cmd.op = OP_SUM_F;
        state_next = st.f_zero ? S_SUM_K : S_SUM_E;
      end
      S_SUM_E: begin
        cmd.op = OP_SUM_E;
        state_next = st.v_out ? S_SUM_F : S_SUM_C;
      end
      S_SUM_C: begin
        cmd.op = OP_SUM_C;
        state_next = st.c_self ? S_SUM_F : S_SUM_B;
      end
      S_SUM_B: begin
        cmd.op = OP_SUM_B;
        state_next = S_SUM_F;
      end
      S_RET: begin
        cmd.op = OP_RET;
        state_next = st.csp_zero ? S_ROOT : S_RET_RD;
      end
      S_RET_RD: begin
        cmd.op = OP_RET_RD;
        state_next = S_EDGE;
      end
      S_DONE: begin
        cmd.op = OP_DONE;
        state_next = S_CLEAR;
      end
      default: begin
        cmd.op = OP_IDLE;
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/scmpw_dpath.sv =====
// Graph stores, DFS stacks, component sums and result register.
module scmpw_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  scmpw_pkg::cmd_t               cmd,
  output scmpw_pkg::stat_t              st,
  input  logic                          cfg_we,
  input  logic [scmpw_pkg::ID_W-1:0]    cfg_data,
  input  logic [1:0]                    func,
  input  logic [scmpw_pkg::ID_W-1:0]    node_id,
  input  logic [scmpw_pkg::WT_W-1:0]    weight,
  input  logic [scmpw_pkg::ID_W-1:0]    edge_source,
  input  logic [scmpw_pkg::ID_W-1:0]    edge_target,
  input  logic                          res_take,
  output logic                          res_valid,
  output logic [scmpw_pkg::SUM_W-1:0]   res_max,
  output logic                          res_ovf
);
  import scmpw_pkg::*;

  localparam logic [ID_W-1:0] ID_MAX = ID_W'(NODE_MAX);

  // memories
  logic [WT_W-1:0]    wt_mem    [NODE_MAX];
  logic [ELINK_W-1:0] head_mem  [NODE_MAX];
  logic [NIDX_W-1:0]  etgt_mem  [EDGE_MAX];
  logic [ELINK_W-1:0] enext_mem [EDGE_MAX];
  logic [CNT_W-1:0]   disc_mem  [NODE_MAX];
  logic               onstk_mem [NODE_MAX];
  logic [NIDX_W-1:0]  nstk_mem  [NODE_MAX];
  frame_t             cstk_mem  [NODE_MAX];
  logic [CNT_W-1:0]   comp_mem  [NODE_MAX];
  logic [SUM_W-1:0]   best_mem  [NODE_MAX];

  logic [WT_W-1:0]    wt_q;
  logic [ELINK_W-1:0] head_q;
  logic [NIDX_W-1:0]  etgt_q;
  logic [ELINK_W-1:0] enext_q;
  logic [CNT_W-1:0]   disc_q;
  logic               onstk_q;
  logic [NIDX_W-1:0]  nstk_q;
  frame_t             cstk_q;
  logic [CNT_W-1:0]   comp_q;
  logic [SUM_W-1:0]   best_q;

  // port controls
  logic wt_we, head_we, etgt_we, enext_we, disc_we, onstk_we, nstk_we, cstk_we, comp_we;
  logic best_we;
  logic [NIDX_W-1:0]  wt_wa, wt_ra, head_wa, head_ra, disc_wa, disc_ra, onstk_wa;
  logic [NIDX_W-1:0]  nstk_wa, nstk_ra, cstk_wa, cstk_ra, comp_wa, comp_ra, best_wa, best_ra;
  logic [EIDX_W-1:0]  edge_wa, edge_ra;
  logic [ELINK_W-1:0] head_wd;
  logic [CNT_W-1:0]   disc_wd;
  logic               onstk_wd;
  logic [NIDX_W-1:0]  nstk_wd;

  // registers
  logic [ID_W-1:0]    node_count;
  logic [CNT_W-1:0]   n_eff, r, stamp, nsp, csp, comps, top, k;
  logic [ELINK_W-1:0] cnt, cur_e, f;
  logic               ovf;
  logic [NIDX_W-1:0]  s_idx, cur_u, v;
  logic [CNT_W-1:0]   cur_low, cur_disc;
  logic [SUM_W-1:0]   answer, csum, child, total;
  logic [NIDX_W-1:0]  clr;

  logic               ends_ok, id_ok;
  logic [ID_W-1:0]    src_m1, tgt_m1, id_m1;
  logic [CNT_W-1:0]   r_m1, nsp_m1, nsp_m2, csp_m1, comps_m1, comp_m1, stamp_p1;
  logic [ELINK_W-1:0] cur_e_m1, f_m1, cnt_m1;

  assign src_m1   = edge_source - ID_W'(1);
  assign tgt_m1   = edge_target - ID_W'(1);
  assign id_m1    = node_id - ID_W'(1);
  assign id_ok    = (node_id != '0) && (node_id <= ID_MAX);
  assign ends_ok  = (edge_source != '0) && (edge_source <= ID_MAX) &&
                    (edge_target != '0) && (edge_target <= ID_MAX);
  assign r_m1     = r - CNT_W'(1);
  assign nsp_m1   = nsp - CNT_W'(1);
  assign nsp_m2   = nsp - CNT_W'(2);
  assign csp_m1   = csp - CNT_W'(1);
  assign comps_m1 = comps - CNT_W'(1);
  assign comp_m1  = comp_q - CNT_W'(1);
  assign stamp_p1 = stamp + CNT_W'(1);
  assign cur_e_m1 = cur_e - ELINK_W'(1);
  assign f_m1     = f - ELINK_W'(1);
  assign cnt_m1   = cnt - ELINK_W'(1);
  assign total    = sat_add(csum, child);

  always_comb begin
    st.res_valid    = res_valid;
    st.item_edge    = (func == FUNC_EDGE) && ends_ok && !cnt[EIDX_W];
    st.item_compute = (func == FUNC_COMPUTE);
    st.root_done    = r > n_eff;
    st.disc_zero    = (disc_q == '0);
    st.e_zero       = (cur_e == '0);
    st.scc_root     = (cur_low == cur_disc);
    st.v_out        = {1'b0, etgt_q} >= n_eff;
    st.pop_last     = (nstk_q == cur_u);
    st.k_end        = (k == top);
    st.f_zero       = (f == '0);
    st.c_self       = (comp_q == comps);
    st.csp_zero     = (csp == '0);
    st.clr_last     = &clr;
  end

  always_comb begin
    wt_we = 1'b0; head_we = 1'b0; etgt_we = 1'b0; enext_we = 1'b0; disc_we = 1'b0;
    onstk_we = 1'b0; nstk_we = 1'b0; cstk_we = 1'b0; comp_we = 1'b0; best_we = 1'b0;
    wt_wa = id_m1[NIDX_W-1:0];
    wt_ra = nstk_q;
    head_wa = s_idx; head_ra = nstk_q; head_wd = cnt;
    edge_wa = cnt[EIDX_W-1:0]; edge_ra = cur_e_m1[EIDX_W-1:0];
    disc_wa = v; disc_ra = etgt_q; disc_wd = stamp_p1;
    onstk_wa = v; onstk_wd = 1'b1;
    nstk_wa = nsp[NIDX_W-1:0]; nstk_ra = nsp_m1[NIDX_W-1:0]; nstk_wd = v;
    cstk_wa = csp[NIDX_W-1:0]; cstk_ra = csp_m1[NIDX_W-1:0];
    comp_wa = nstk_q; comp_ra = etgt_q;
    best_wa = comps_m1[NIDX_W-1:0]; best_ra = comp_m1[NIDX_W-1:0];
    case (cmd.op)
      OP_CLEAR: begin
        head_we = 1'b1; head_wa = clr; head_wd = '0;
        disc_we = 1'b1; disc_wa = clr; disc_wd = '0;
        onstk_we = 1'b1; onstk_wa = clr; onstk_wd = 1'b0;
      end
      OP_IDLE: begin
        head_ra = src_m1[NIDX_W-1:0];
        wt_we   = cmd.accept && (func == FUNC_WEIGHT) && id_ok;
        etgt_we = cmd.accept && st.item_edge;
      end
      OP_LINK: begin
        head_we = 1'b1;
        enext_we = 1'b1; edge_wa = cnt_m1[EIDX_W-1:0];
      end
      OP_ROOT: disc_ra = r_m1[NIDX_W-1:0];
      OP_ROOT_CHK: begin
        head_ra = r_m1[NIDX_W-1:0];
        disc_we = st.disc_zero; disc_wa = r_m1[NIDX_W-1:0];
        onstk_we = st.disc_zero; onstk_wa = r_m1[NIDX_W-1:0];
        nstk_we = st.disc_zero; nstk_wd = r_m1[NIDX_W-1:0];
      end
      OP_NBR: begin
        head_ra = v;
        disc_we = st.disc_zero;
        onstk_we = st.disc_zero;
        nstk_we = st.disc_zero;
        cstk_we = st.disc_zero;
      end
      OP_POP: begin
        onstk_we = 1'b1; onstk_wa = nstk_q; onstk_wd = 1'b0;
        comp_we = 1'b1;
        nstk_ra = nsp_m2[NIDX_W-1:0];
      end
      OP_SUM_K: begin
        nstk_ra = k[NIDX_W-1:0];
        best_we = st.k_end;
      end
      OP_SUM_F: edge_ra = f_m1[EIDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= weight;
    wt_q <= wt_mem[wt_ra];
  end
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (etgt_we) etgt_mem[edge_wa] <= tgt_m1[NIDX_W-1:0];
    etgt_q <= etgt_mem[edge_ra];
  end
  always_ff @(posedge clk) begin
    if (enext_we) enext_mem[edge_wa] <= head_q;
    enext_q <= enext_mem[edge_ra];
  end
  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_q <= disc_mem[disc_ra];
  end
  always_ff @(posedge clk) begin
    if (onstk_we) onstk_mem[onstk_wa] <= onstk_wd;
    onstk_q <= onstk_mem[disc_ra];
  end
  always_ff @(posedge clk) begin
    if (nstk_we) nstk_mem[nstk_wa] <= nstk_wd;
    nstk_q <= nstk_mem[nstk_ra];
  end
  always_ff @(posedge clk) begin
    if (cstk_we) cstk_mem[cstk_wa] <= '{node: cur_u, edge_ptr: cur_e, low: cur_low,
                                       disc: cur_disc};
    cstk_q <= cstk_mem[cstk_ra];
  end
  always_ff @(posedge clk) begin
    if (comp_we) comp_mem[comp_wa] <= comps;
    comp_q <= comp_mem[comp_ra];
  end
  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_wa] <= total;
    best_q <= best_mem[best_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= ID_W'(1);
      cnt        <= '0;
      ovf        <= 1'b0;
      res_valid  <= 1'b0;
      clr        <= '0;
    end else begin
      if (cfg_we) node_count <= cfg_data;
      if (res_take) res_valid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr <= clr + NIDX_W'(1);
        OP_IDLE: begin
          if (cmd.accept && (func == FUNC_EDGE) && ends_ok) begin
            if (cnt[EIDX_W]) begin
              ovf <= 1'b1;
            end else begin
              cnt   <= cnt + ELINK_W'(1);
              s_idx <= src_m1[NIDX_W-1:0];
            end
          end
          if (cmd.accept && st.item_compute) begin
            n_eff  <= (node_count > ID_MAX) ? CNT_W'(NODE_MAX) : CNT_W'(node_count);
            r      <= CNT_W'(1);
            stamp  <= '0;
            nsp    <= '0;
            csp    <= '0;
            comps  <= '0;
            answer <= '0;
          end
        end
        OP_ROOT_CHK: begin
          r <= r + CNT_W'(1);
          if (st.disc_zero) begin
            cur_u    <= r_m1[NIDX_W-1:0];
            stamp    <= stamp_p1;
            nsp      <= nsp + CNT_W'(1);
            cur_low  <= stamp_p1;
            cur_disc <= stamp_p1;
          end
        end
        OP_HEAD: cur_e <= head_q;
        OP_EDGE: begin
          if (st.e_zero && st.scc_root) begin
            comps <= comps + CNT_W'(1);
            top   <= nsp;
          end
        end
        OP_EDGE_RD: begin
          cur_e <= enext_q;
          v     <= etgt_q;
        end
        OP_NBR: begin
          if (st.disc_zero) begin
            csp      <= csp + CNT_W'(1);
            stamp    <= stamp_p1;
            nsp      <= nsp + CNT_W'(1);
            cur_u    <= v;
            cur_low  <= stamp_p1;
            cur_disc <= stamp_p1;
          end else if (onstk_q && (disc_q < cur_low)) begin
            cur_low <= disc_q;
          end
        end
        OP_POP: begin
          nsp <= nsp_m1;
          if (st.pop_last) begin
            k     <= nsp_m1;
            csum  <= '0;
            child <= '0;
          end
        end
        OP_SUM_K: if (st.k_end && (total > answer)) answer <= total;
        OP_SUM_H: begin
          csum <= sat_add(csum, SUM_W'(wt_q));
          f    <= head_q;
          k    <= k + CNT_W'(1);
        end
        OP_SUM_E: f <= enext_q;
        OP_SUM_B: if (best_q > child) child <= best_q;
        OP_RET_RD: begin
          cur_u    <= cstk_q.node;
          cur_e    <= cstk_q.edge_ptr;
          cur_disc <= cstk_q.disc;
          cur_low  <= (cur_low < cstk_q.low) ? cur_low : cstk_q.low;
          csp      <= csp_m1;
        end
        OP_DONE: begin
          res_valid <= 1'b1;
          res_max   <= answer;
          res_ovf   <= ovf;
          ovf       <= 1'b0;
          cnt       <= '0;
          clr       <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/scc_condensed_max_path_weight_top.sv =====
// Top level: largest component-weight path through the SCC condensation of a graph.
//
//  channel      | handshake                          | payload
//  -------------+------------------------------------+------------------------------------
//  input item   | in_valid / in_stall                | func node_id weight edge_source
//               |                                    | edge_target
//  result item  | out_valid / out_stall              | max_path_weight edge_overflow
//  node_count   | node_count_valid / node_count_ready| node_count
//
// A weight load is written directly; an edge load first reads the head of its list, then links.
// A compute item walks the graph with one shared set of single-port-read memories:
// a root scan, the search over nodes and edges, the component sums over each
// finished component's nodes and edges, then a clearing pass that wipes list heads
// and visit marks.
// Reset starts the same clearing pass; input items stall until it ends.
// A compute item stalls while a result still waits.
module scc_condensed_max_path_weight_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          node_count_valid,
  output logic                          node_count_ready,
  input  logic [scmpw_pkg::ID_W-1:0]    node_count,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [scmpw_pkg::ID_W-1:0]    node_id,
  input  logic [scmpw_pkg::WT_W-1:0]    weight,
  input  logic [scmpw_pkg::ID_W-1:0]    edge_source,
  input  logic [scmpw_pkg::ID_W-1:0]    edge_target,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scmpw_pkg::SUM_W-1:0]   max_path_weight,
  output logic                          edge_overflow
);
  import scmpw_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Config must only be written while idle; the block does not enforce it, so always take it.
  assign node_count_ready = 1'b1;

  scmpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath holds all stores and the result register; drop the result when taken.
  scmpw_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (node_count_valid),
    .cfg_data    (node_count),
    .func        (func),
    .node_id     (node_id),
    .weight      (weight),
    .edge_source (edge_source),
    .edge_target (edge_target),
    .res_take    (out_valid && !out_stall),
    .res_valid   (out_valid),
    .res_max     (max_path_weight),
    .res_ovf     (edge_overflow)
  );

endmodule

// ===== sv/scmpw_checker.sv =====
// Port-level checks for the SCC path-weight block, bound to the top level.
module scmpw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    func,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [scmpw_pkg::SUM_W-1:0]   max_path_weight,
  input logic                          edge_overflow
);
  import scmpw_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_path_weight) &&
    $stable(edge_overflow))
    else $error("result changed while stalled");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("second result without a compute");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_COMPUTE |=> in_stall)
    else $error("item taken during compute");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

endmodule

bind scc_condensed_max_path_weight_top scmpw_checker u_scmpw_checker (.*);

// ===== tb/path_weight_checker.sv =====
// Checker for the SCC condensation path-weight block: predicts and compares results.
module path_weight_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        node_count_valid,
  input  logic                        node_count_ready,
  input  logic [scmpw_pkg::ID_W-1:0]  node_count,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [scmpw_pkg::ID_W-1:0]  node_id,
  input  logic [scmpw_pkg::WT_W-1:0]  weight,
  input  logic [scmpw_pkg::ID_W-1:0]  edge_source,
  input  logic [scmpw_pkg::ID_W-1:0]  edge_target,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [scmpw_pkg::SUM_W-1:0] max_path_weight,
  input  logic                        edge_overflow,
  output int                          fail_count,
  output int                          pending,
  output int                          computes_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import scmpw_pkg::*;

  typedef struct {
    logic [SUM_W-1:0] path_sum;
    logic             dropped;
  } path_result_t;

  path_result_t expected_paths[$];

  logic [ID_W-1:0]  graph_nodes;
  logic [WT_W-1:0]  node_wt [NODE_MAX+1];
  int               list_head [NODE_MAX+1];
  int               edge_head_node [EDGE_MAX+1];
  int               edge_link [EDGE_MAX+1];
  int               stored_edges;
  logic             edges_dropped;

  int               disc [NODE_MAX+1];
  int               low [NODE_MAX+1];
  bit               on_stk [NODE_MAX+1];
  int               comp [NODE_MAX+1];
  logic [SUM_W-1:0] best [NODE_MAX+1];
  int               node_stk [NODE_MAX];
  int               walk_node [NODE_MAX];
  int               walk_edge [NODE_MAX];

  function automatic logic [SUM_W-1:0] clamp_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s > {1'b0, SUM_MAX} ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Tarjan search with explicit stacks; each component closes in reverse topological order.
  function logic [SUM_W-1:0] longest_condensed_path(int n);
    int stamp, nsp, csp, comps, u, e, v, p, base, top, w, f, c;
    logic [SUM_W-1:0] answer, csum, child;
    stamp = 0; nsp = 0; csp = 0; comps = 0; answer = '0;
    for (int r = 1; r <= n; r++) begin
      if (disc[r] != 0) continue;
      stamp++;
      disc[r] = stamp; low[r] = stamp;
      node_stk[nsp++] = r; on_stk[r] = 1;
      walk_node[csp] = r; walk_edge[csp] = list_head[r]; csp++;
      while (csp > 0) begin
        u = walk_node[csp-1];
        e = walk_edge[csp-1];
        if (e != 0) begin
          v = edge_head_node[e];
          walk_edge[csp-1] = edge_link[e];
          if (v == 0 || v > n) continue;
          if (disc[v] == 0) begin
            stamp++;
            disc[v] = stamp; low[v] = stamp;
            node_stk[nsp++] = v; on_stk[v] = 1;
            walk_node[csp] = v; walk_edge[csp] = list_head[v]; csp++;
          end else if (on_stk[v] && disc[v] < low[u]) begin
            low[u] = disc[v];
          end
          continue;
        end
        csp--;
        if (low[u] == disc[u]) begin
          top = nsp; base = nsp; csum = '0; child = '0;
          comps++;
          while (base > 0) begin
            base--;
            w = node_stk[base];
            on_stk[w] = 0;
            comp[w] = comps;
            if (w == u) break;
          end
          nsp = base;
          for (int k = base; k < top; k++) begin
            w = node_stk[k];
            csum = clamp_sum(csum, SUM_W'(node_wt[w]));
            for (f = list_head[w]; f != 0; f = edge_link[f]) begin
              v = edge_head_node[f];
              if (v == 0 || v > n) continue;
              c = comp[v];
              if (c != comps && c <= NODE_MAX && best[c] > child) child = best[c];
            end
          end
          best[comps] = clamp_sum(csum, child);
          if (best[comps] > answer) answer = best[comps];
        end
        if (csp > 0) begin
          p = walk_node[csp-1];
          if (low[u] < low[p]) low[p] = low[u];
        end
      end
    end
    return answer;
  endfunction

  function void wipe_graph();
    for (int i = 0; i <= NODE_MAX; i++) begin
      list_head[i] = 0; disc[i] = 0; on_stk[i] = 0; best[i] = '0;
    end
    stored_edges = 0;
    edges_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    path_result_t got, exp_r;
    int n;
    if (rst) begin
      graph_nodes <= ID_W'(1);
      for (int i = 0; i <= NODE_MAX; i++) begin
        node_wt[i] = '0; comp[i] = 0;
      end
      wipe_graph();
      expected_paths.delete();
      fail_count <= 0;
      computes_seen <= 0;
    end else begin
      if (node_count_valid && node_count_ready) graph_nodes <= node_count;
      if (in_valid && !in_stall) begin
        case (func)
          FUNC_WEIGHT: begin
            if (node_id >= 1 && node_id <= NODE_MAX) node_wt[node_id] = weight;
          end
          FUNC_EDGE: begin
            if (edge_source >= 1 && edge_source <= NODE_MAX &&
                edge_target >= 1 && edge_target <= NODE_MAX) begin
              if (stored_edges >= EDGE_MAX) begin
                edges_dropped = 1'b1;
              end else begin
                stored_edges++;
                edge_head_node[stored_edges] = int'(edge_target);
                edge_link[stored_edges] = list_head[edge_source];
                list_head[edge_source] = stored_edges;
              end
            end
          end
          FUNC_COMPUTE: begin
            n = (int'(graph_nodes) > NODE_MAX) ? NODE_MAX : int'(graph_nodes);
            exp_r.path_sum = longest_condensed_path(n);
            exp_r.dropped = edges_dropped;
            expected_paths.push_back(exp_r);
            computes_seen <= computes_seen + 1;
            wipe_graph();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.path_sum = max_path_weight;
        got.dropped = edge_overflow;
        if (expected_paths.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: result with none expected: weight %0d overflow %0b",
                     got.path_sum, got.dropped);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_paths.pop_front();
          if (got.path_sum !== exp_r.path_sum || got.dropped !== exp_r.dropped) begin
            if (fail_count < 10)
              $display("ERROR: expected weight %0d overflow %0b, got weight %0d overflow %0b",
                       exp_r.path_sum, exp_r.dropped, got.path_sum, got.dropped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_paths.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives graph loads and computes into the path-weight block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scmpw_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 200000;

  logic             clk;
  logic             rst;
  logic             node_count_valid;
  logic             node_count_ready;
  logic [ID_W-1:0]  node_count;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       func;
  logic [ID_W-1:0]  node_id;
  logic [WT_W-1:0]  weight;
  logic [ID_W-1:0]  edge_source;
  logic [ID_W-1:0]  edge_target;
  logic             out_valid;
  logic             out_stall;
  logic [SUM_W-1:0] max_path_weight;
  logic             edge_overflow;

  int  fail_count;
  int  pending;
  int  computes_seen;
  int  items_sent;
  int  quiet_cycles;
  int  stall_left;
  bit  quiet;

  scc_condensed_max_path_weight_top u_top (.*);

  path_weight_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: stall in random bursts, none once the quiet tail starts.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (node_count_valid && node_count_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic [1:0] f, logic [ID_W-1:0] id, logic [WT_W-1:0] w,
                           logic [ID_W-1:0] src, logic [ID_W-1:0] dst);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    func = f; node_id = id; weight = w; edge_source = src; edge_target = dst;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_weight(int id, int w);
    send_item(FUNC_WEIGHT, ID_W'(id), WT_W'(w), ID_W'($urandom), ID_W'($urandom));
  endtask

  task automatic add_edge(int src, int dst);
    send_item(FUNC_EDGE, ID_W'($urandom), WT_W'($urandom), ID_W'(src), ID_W'(dst));
  endtask

  task automatic compute();
    send_item(FUNC_COMPUTE, ID_W'($urandom), WT_W'($urandom), ID_W'($urandom),
              ID_W'($urandom));
  endtask

  // Drain results, let the clearing pass finish, then write the node count.
  task automatic set_node_count(int n);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (5000) @(posedge clk);
    @(negedge clk);
    node_count_valid = 1'b1;
    node_count = ID_W'(n);
    do @(posedge clk); while (!node_count_ready);
    @(negedge clk);
    node_count_valid = 1'b0;
  endtask

  task automatic load_all_weights(int n);
    for (int i = 1; i <= n; i++) begin
      case ($urandom_range(0, 7))
        0: load_weight(i, 0);
        1: load_weight(i, 16'hFFFF);
        default: load_weight(i, $urandom_range(0, 65535));
      endcase
    end
  endtask

  // One random graph: mostly edges inside the graph, with some noise mixed in.
  task automatic random_graph(int n);
    int edges;
    edges = $urandom_range(0, 2 * n);
    for (int i = 0; i < edges; i++) begin
      case ($urandom_range(0, 19))
        0: add_edge(0, $urandom_range(1, n));
        1: add_edge($urandom_range(1, n), $urandom_range(4097, 8191));
        2: add_edge($urandom_range(1, n), $urandom_range(n + 1, NODE_MAX));
        3: send_item(FUNC_UNUSED, ID_W'($urandom), WT_W'($urandom), ID_W'($urandom),
                     ID_W'($urandom));
        4: load_weight($urandom_range(1, n), $urandom_range(0, 65535));
        5: load_weight($urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191), $urandom);
        default: add_edge($urandom_range(1, n), $urandom_range(1, n));
      endcase
    end
    compute();
  endtask

  initial begin
    int n;
    rst = 1'b1;
    quiet = 1'b0;
    items_sent = 0;
    node_count_valid = 1'b0;
    node_count = '0;
    in_valid = 1'b0;
    func = FUNC_WEIGHT;
    node_id = '0; weight = '0; edge_source = '0; edge_target = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, ignored items, a cycle, a self loop, edges past the graph.
    set_node_count(5);
    load_weight(1, 0);
    load_weight(2, 16'hFFFF);
    load_weight(3, 16'h1234);
    load_weight(4, 16'hFFFF);
    load_weight(5, 7);
    load_weight(0, 16'hFFFF);
    load_weight(8191, 16'hFFFF);
    load_weight(4097, 1);
    send_item(FUNC_UNUSED, ID_W'(8191), 16'hFFFF, ID_W'(8191), ID_W'(8191));
    add_edge(0, 2);
    add_edge(3, 8191);
    add_edge(8191, 0);
    add_edge(1, 2);
    add_edge(2, 1);
    add_edge(2, 3);
    add_edge(3, 4);
    add_edge(1, 4);
    add_edge(5, 5);
    add_edge(4, NODE_MAX);
    compute();
    compute();

    // Empty graph: a count of zero answers zero.
    set_node_count(0);
    add_edge(1, 2);
    compute();

    // Random graphs over a spread of sizes.
    while (items_sent < 420) begin
      case ($urandom_range(0, 3))
        0: n = 1;
        1: n = 2;
        default: n = $urandom_range(3, 24);
      endcase
      set_node_count(n);
      load_all_weights(n);
      repeat ($urandom_range(1, 4)) random_graph(n);
    end

    // Quiet tail: small graphs back to back with no stalls.
    quiet = 1'b1;
    set_node_count(3);
    add_edge(1, 2);
    add_edge(2, 3);
    compute();
    add_edge(3, 1);
    compute();

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (5000) @(posedge clk);
    $display("Run covered %0d input items and %0d graph computes on graphs of up to 24 nodes,",
             items_sent, computes_seen);
    $display("with ignored items, out-of-range edge ends and random stalls on both channels.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
